// ===== hw/rtl/imu_fp_pkg.sv =====
// Shared constants and types for the IMU serial frame parser.
`timescale 1ns / 1ps

package imu_fp_pkg;

    // Frame bytes
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Frame positions
    localparam int         FRAME_LEN   = 11;
    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_DATA0   = 4'd2;
    localparam logic [3:0] POS_DATA_HI = 4'd7;
    localparam logic [3:0] POS_CSUM    = 4'(FRAME_LEN - 1);

    // Field widths
    localparam int SCALE_W = 20;
    localparam int VALUE_W = 21;
    localparam int RAW_W   = 16;
    localparam int PROD_W  = RAW_W + SCALE_W + 1;
    localparam int FRAC_SHIFT = 15;

    // Register map
    localparam int          PADDR_W    = 4;
    localparam logic [1:0]  REG_ACCEL  = 2'd0;
    localparam logic [1:0]  REG_RATE   = 2'd1;
    localparam logic [1:0]  REG_ANGLE  = 2'd2;

    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 20'd40141;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 20'd512000;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 20'd46080;

    // Frame kinds
    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } frame_kind_t;

    // Scale one raw sample: floor((raw * scale) / 2^15)
    function automatic logic [VALUE_W-1:0] scale_value(
        input logic signed [RAW_W-1:0] raw,
        input logic [SCALE_W-1:0]      scale
    );
        logic signed [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * $signed({1'b0, scale});
        return prod[FRAC_SHIFT + VALUE_W - 1:FRAC_SHIFT];
    endfunction

endpackage

// ===== hw/rtl/imu_frame_parser_unit.sv =====
// Top level of the IMU serial frame parser: byte parser, frame register, scaled output.
// A checked frame is registered in the frame register, then in the output register.
// Throughput: one byte per cycle while s_tready is high; the frame register and output register
// form a two-deep pipeline, so s_tready falls only when both hold a result and m_tready is low.
// Scaling uses three 16x21 multipliers in parallel between the frame and output registers.
// Reset (rst_n, asynchronous, active low) clears the parser to hunting and restores default scales.
`timescale 1ns / 1ps

module imu_frame_parser_unit
    import imu_fp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Byte stream in
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    // Result stream out
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,   // [20:0] value_x, [41:21] value_y, [62:42] value_z, [63] zero
    output logic [1:0]         m_tuser,   // [1:0] frame_kind
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [SCALE_W-1:0] accel_scale_reg;
    logic [SCALE_W-1:0] rate_scale_reg;
    logic [SCALE_W-1:0] angle_scale_reg;
    logic               cfg_write;

    // Parser state
    logic [3:0]  pos_reg,  pos_next;
    logic [7:0]  sum_reg,  sum_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  payload_reg [6];
    logic        payload_we;
    logic [2:0]  payload_idx;

    // Frame register
    logic                      frame_valid_reg, frame_valid_next;
    logic [1:0]                frame_kind_reg;
    logic signed [RAW_W-1:0]   frame_raw_reg [3];
    logic [SCALE_W-1:0]        frame_scale_reg;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_kind_reg;
    logic [VALUE_W-1:0]   out_val_reg [3];

    logic accept;
    logic frame_hit;
    logic frame_ready;
    logic out_load;
    logic [SCALE_W-1:0] sel_scale;

    // Handshake
    assign out_load    = !out_valid_reg || m_tready;
    assign frame_ready = !frame_valid_reg || out_load;
    assign s_tready    = frame_ready;
    assign accept      = s_tvalid && s_tready;

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_ACCEL: prdata = 32'(accel_scale_reg);
            REG_RATE:  prdata = 32'(rate_scale_reg);
            REG_ANGLE: prdata = 32'(angle_scale_reg);
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg <= ACCEL_SCALE_RST;
            rate_scale_reg  <= RATE_SCALE_RST;
            angle_scale_reg <= ANGLE_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ACCEL: accel_scale_reg <= pwdata[SCALE_W-1:0];
                REG_RATE:  rate_scale_reg  <= pwdata[SCALE_W-1:0];
                REG_ANGLE: angle_scale_reg <= pwdata[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Byte parser: advance position, running checksum and payload capture
    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        kind_next   = kind_reg;
        frame_hit   = 1'b0;
        payload_we  = 1'b0;
        payload_idx = 3'(pos_reg - POS_DATA0);
        if (accept)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (s_tdata == HDR_BYTE)
                begin
                    sum_next = HDR_BYTE;
                    pos_next = POS_TYPE;
                end
            end
            else if (pos_reg == POS_TYPE)
            begin
                if (s_tdata == TYPE_ACC || s_tdata == TYPE_RATE || s_tdata == TYPE_ANGLE)
                begin
                    kind_next = 2'(s_tdata - TYPE_ACC);
                    sum_next  = sum_reg + s_tdata;
                    pos_next  = POS_DATA0;
                end
                else if (s_tdata == HDR_BYTE)
                begin
                    sum_next = HDR_BYTE;
                    pos_next = POS_TYPE;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_reg < POS_CSUM)
            begin
                payload_we = (pos_reg <= POS_DATA_HI);
                sum_next   = sum_reg + s_tdata;
                pos_next   = pos_reg + 4'd1;
            end
            else
            begin
                // Checksum byte: drop on mismatch
                pos_next  = POS_HUNT;
                frame_hit = (s_tdata == sum_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_HUNT;
            sum_reg  <= 8'd0;
            kind_reg <= KIND_ACC;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload_we)
            payload_reg[payload_idx] <= s_tdata;
    end

    // Select the scale of the held frame kind
    always_comb
    begin
        case (kind_reg)
            KIND_ACC:  sel_scale = accel_scale_reg;
            KIND_RATE: sel_scale = rate_scale_reg;
            default:   sel_scale = angle_scale_reg;
        endcase
    end

    // Frame register: hold raw samples of a checked frame
    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (frame_ready)
            frame_valid_next = frame_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_valid_reg <= 1'b0;
        else
            frame_valid_reg <= frame_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (frame_hit)
        begin
            frame_kind_reg   <= kind_reg;
            frame_scale_reg  <= sel_scale;
            frame_raw_reg[0] <= {payload_reg[1], payload_reg[0]};
            frame_raw_reg[1] <= {payload_reg[3], payload_reg[2]};
            frame_raw_reg[2] <= {payload_reg[5], payload_reg[4]};
        end
    end

    // Output register: scale the three samples
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = frame_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && frame_valid_reg)
        begin
            out_kind_reg   <= frame_kind_reg;
            out_val_reg[0] <= scale_value(frame_raw_reg[0], frame_scale_reg);
            out_val_reg[1] <= scale_value(frame_raw_reg[1], frame_scale_reg);
            out_val_reg[2] <= scale_value(frame_raw_reg[2], frame_scale_reg);
        end
    end

    // Drive the result stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {1'b0, out_val_reg[2], out_val_reg[1], out_val_reg[0]};

endmodule
